FILE: hdl/ps2mt_pkg.sv
`default_nettype none
package ps2mt_pkg;

  localparam int COORD_BITS = 12;
  localparam int SIZE_W     = 13;
  localparam int DECIM_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int BTN_W      = 3;
  localparam int WIDE_W     = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION    = 2'd2;

  localparam logic [SIZE_W-1:0]  RST_SCREEN_WIDTH  = 13'd80;
  localparam logic [SIZE_W-1:0]  RST_SCREEN_HEIGHT = 13'd25;
  localparam logic [DECIM_W-1:0] RST_DECIMATION    = 8'd1;

  localparam int HDR_ALWAYS_ONE_BIT = 3;
  localparam int HDR_X_OVF_BIT      = 6;
  localparam int HDR_Y_OVF_BIT      = 7;

  localparam logic [DECIM_W-1:0] TALLY_MAX = {DECIM_W{1'b1}};

  localparam int RES_BITS = BTN_W + 2 * BYTE_W + 2 * COORD_BITS + 1;
  localparam int M_DATA_W = ((RES_BITS + 7) / 8) * 8;
  localparam int S_DATA_W = BYTE_W;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

  typedef struct packed {
    logic                  moved;
    logic [COORD_BITS-1:0] pointer_y;
    logic [COORD_BITS-1:0] pointer_x;
    logic [BYTE_W-1:0]     delta_y;
    logic [BYTE_W-1:0]     delta_x;
    logic [BTN_W-1:0]      button_bits;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/ps2mt_clamp.sv
`default_nettype none
module ps2mt_clamp (
  input  wire logic [ps2mt_pkg::COORD_BITS-1:0] cursor,
  input  wire logic signed [ps2mt_pkg::BYTE_W-1:0] delta,
  input  wire logic                             negate,
  input  wire logic                             apply,
  input  wire logic [ps2mt_pkg::SIZE_W-1:0]     size,
  output logic      [ps2mt_pkg::COORD_BITS-1:0] cursor_next
);
  import ps2mt_pkg::*;

  localparam logic signed [WIDE_W-1:0] COORD_MAX_W =
    WIDE_W'((1 << COORD_BITS) - 1);

  logic signed [WIDE_W-1:0] base;
  logic signed [WIDE_W-1:0] step;
  logic signed [WIDE_W-1:0] sum;
  logic signed [WIDE_W-1:0] lim_raw;
  logic signed [WIDE_W-1:0] lim;
  logic signed [WIDE_W-1:0] clamped;

  always_comb begin
    base    = signed'({{(WIDE_W-COORD_BITS){1'b0}}, cursor});
    step    = WIDE_W'(delta);
    sum     = apply ? (negate ? base - step : base + step) : base;
    lim_raw = signed'({{(WIDE_W-SIZE_W){1'b0}}, size}) - WIDE_W'(1);
    priority if (size == '0) begin
      lim = '0;
    end else if (lim_raw > COORD_MAX_W) begin
      lim = COORD_MAX_W;
    end else begin
      lim = lim_raw;
    end
    priority if (sum < 0) begin
      clamped = '0;
    end else if (sum > lim) begin
      clamped = lim;
    end else begin
      clamped = sum;
    end
    cursor_next = clamped[COORD_BITS-1:0];
  end

endmodule
`default_nettype wire

FILE: hdl/ps2_mouse_packet_tracker_core.sv
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata: rx_byte
// m_*       out  m_tvalid/m_tready   m_tdata: packet result
// cfg_*     in   cfg_we              cfg_index, cfg_data
//
// One byte per cycle while s_tready is high; an overflow-free packet's result appears the cycle after its third byte.
// Throughput is set by the single output register: it refills while it drains.
// Reset clears phase, cursor, tally, output valid and loads default settings.
// s_tready drops only while a result waits and m_tready is low.
`default_nettype none
module ps2_mouse_packet_tracker_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [ps2mt_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] rx_byte
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [2:0] button_bits, [10:3] delta_x, [18:11] delta_y, [30:19] pointer_x,
  // [42:31] pointer_y, [43] moved, [47:44] zero
  output logic      [ps2mt_pkg::M_DATA_W-1:0]   m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [ps2mt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ps2mt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ps2mt_pkg::*;

  logic [SIZE_W-1:0]     screen_width;
  logic [SIZE_W-1:0]     screen_height;
  logic [DECIM_W-1:0]    decimation_count;

  phase_t                phase;
  phase_t                phase_next;
  logic [BYTE_W-1:0]     header_byte;
  logic [BYTE_W-1:0]     x_byte;
  logic [COORD_BITS-1:0] cursor_col;
  logic [COORD_BITS-1:0] cursor_row;
  logic [DECIM_W-1:0]    packet_tally;

  logic [COORD_BITS-1:0] cursor_col_next;
  logic [COORD_BITS-1:0] cursor_row_next;
  logic [DECIM_W-1:0]    tally_inc;
  logic [DECIM_W-1:0]    tally_next;
  logic                  accept;
  logic                  overflow;
  logic                  packet_done;
  logic                  apply;
  logic                  out_valid;
  result_t               res;
  result_t               res_next;

  assign accept      = s_tvalid && s_tready;
  assign s_tready    = !out_valid || m_tready;
  assign overflow    = header_byte[HDR_X_OVF_BIT] || header_byte[HDR_Y_OVF_BIT];
  assign packet_done = accept && (phase == PH_Y) && !overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= RST_SCREEN_WIDTH;
      screen_height    <= RST_SCREEN_HEIGHT;
      decimation_count <= RST_DECIMATION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width     <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height    <= cfg_data;
        CFG_DECIMATION:    decimation_count <= cfg_data[DECIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_X:    phase_next = PH_Y;
        PH_Y:    phase_next = PH_HEADER;
        default: phase_next = s_tdata[HDR_ALWAYS_ONE_BIT] ? PH_X : PH_HEADER;
      endcase
    end
  end

  always_comb begin
    tally_inc = (packet_tally == TALLY_MAX) ? TALLY_MAX : packet_tally + DECIM_W'(1);
    apply     = tally_inc >= decimation_count;
    tally_next = apply ? '0 : tally_inc;
  end

  ps2mt_clamp u_clamp_col (
    .cursor      (cursor_col),
    .delta       (signed'(x_byte)),
    .negate      (1'b0),
    .apply       (apply),
    .size        (screen_width),
    .cursor_next (cursor_col_next)
  );

  ps2mt_clamp u_clamp_row (
    .cursor      (cursor_row),
    .delta       (signed'(s_tdata)),
    .negate      (1'b1),
    .apply       (apply),
    .size        (screen_height),
    .cursor_next (cursor_row_next)
  );

  always_comb begin
    res_next.button_bits = header_byte[BTN_W-1:0];
    res_next.delta_x     = x_byte;
    res_next.delta_y     = s_tdata;
    res_next.pointer_x   = cursor_col_next;
    res_next.pointer_y   = cursor_row_next;
    res_next.moved       = apply;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_byte  <= '0;
      x_byte       <= '0;
      cursor_col   <= '0;
      cursor_row   <= '0;
      packet_tally <= '0;
    end else begin
      phase <= phase_next;
      if (accept && (phase != PH_X) && (phase != PH_Y)) begin
        header_byte <= s_tdata;
      end
      if (accept && (phase == PH_X)) begin
        x_byte <= s_tdata;
      end
      if (packet_done) begin
        cursor_col   <= cursor_col_next;
        cursor_row   <= cursor_row_next;
        packet_tally <= tally_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (packet_done) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (packet_done) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W-RES_BITS){1'b0}}, res};

  a_packet_yields_result: assert property (@(posedge clk) disable iff (rst)
    packet_done |=> m_tvalid)
    else $error("completed packet did not produce a result");

  a_tally_holds_off_packet: assert property (@(posedge clk) disable iff (rst)
    (accept && phase != PH_Y) |=> $stable(packet_tally) && $stable(cursor_col))
    else $error("tally or cursor changed outside a completed packet");

  a_moved_clears_tally: assert property (@(posedge clk) disable iff (rst)
    (packet_done && apply) |=> (packet_tally == '0) && m_tdata[RES_BITS-1])
    else $error("applied movement did not clear tally or flag moved");

  a_overflow_drops: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_Y && overflow && !m_tready && out_valid) |=>
      $stable(res))
    else $error("overflow packet disturbed a pending result");

endmodule
`default_nettype wire
